@@ design/acde_pkg.sv @@
// Package for the alarm clock with digit edit: item codes, state and display
// structs, reset values and the seven-segment encoder.
// No dependencies.
package acde_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_BUTTON = 2'd1;
  localparam logic [1:0] CMD_SWITCH = 2'd2;

  localparam logic [3:0] BTN_ADD  = 4'd11;
  localparam logic [3:0] BTN_SUB  = 4'd7;
  localparam logic [3:0] BTN_NEXT = 4'd13;
  localparam logic [3:0] BTN_OFF  = 4'd14;

  localparam int SW_EDIT_TIME  = 0;
  localparam int SW_EDIT_ALARM = 1;
  localparam int SW_ARM_ON     = 2;

  localparam logic [6:0] SEG_BLANK = 7'd127;

  localparam logic [1:0] LAMP_PH0  = 2'd1;
  localparam logic [1:0] LAMP_PH1  = 2'd2;
  localparam logic [1:0] LAMP_IDLE = 2'd3;

  localparam logic [5:0] MIN_WRAP  = 6'd60;
  localparam logic [4:0] HOUR_WRAP = 5'd24;
  localparam logic [5:0] RING_SEC  = 6'd3;

  localparam logic [6:0] SEG_TABLE [10] = '{
    7'd64, 7'd121, 7'd36, 7'd48, 7'd25, 7'd18, 7'd2, 7'd120, 7'd0, 7'd16
  };

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [5:0] alarm_min;
    logic [4:0] alarm_hour;
    logic [1:0] digit_sel;
    logic       edit_time;
    logic       edit_alarm;
    logic       arm_on;
    logic       ringing;
    logic [1:0] lamp;
    logic       blink;
  } clk_state_t;

  typedef struct packed {
    logic [6:0] min_ones_seg;
    logic [6:0] min_tens_seg;
    logic [6:0] hour_ones_seg;
    logic [6:0] hour_tens_seg;
    logic       ring_blink;
    logic       alarm_armed;
    logic [1:0] alarm_lamp;
  } disp_t;

  localparam clk_state_t ST_RESET = '{
    sec:        6'd55,
    min:        6'd59,
    hour:       5'd23,
    alarm_min:  6'd0,
    alarm_hour: 5'd17,
    digit_sel:  2'd0,
    edit_time:  1'b0,
    edit_alarm: 1'b0,
    arm_on:     1'b0,
    ringing:    1'b0,
    lamp:       LAMP_IDLE,
    blink:      1'b1
  };

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    if (d < 4'd10) begin
      s = SEG_TABLE[d];
    end else begin
      s = SEG_BLANK;
    end
    return s;
  endfunction

  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) begin
      t = 3'd6;
    end else if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(tens_of(v)) * 6'd10;
    return r[3:0];
  endfunction

endpackage

@@ design/acde_if.sv @@
// Channel interfaces of the alarm clock: command beats in, display beats out.
// No dependencies.
interface acde_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] button_code;
  logic [2:0] switch_bits;

  modport source (output valid, cmd, button_code, switch_bits, input ready);
  modport sink   (input valid, cmd, button_code, switch_bits, output ready);
endinterface

interface acde_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] min_ones_seg;
  logic [6:0] min_tens_seg;
  logic [6:0] hour_ones_seg;
  logic [6:0] hour_tens_seg;
  logic       ring_blink;
  logic       alarm_armed;
  logic [1:0] alarm_lamp;

  modport source (output valid, min_ones_seg, min_tens_seg, hour_ones_seg, hour_tens_seg,
                  ring_blink, alarm_armed, alarm_lamp, input ready);
  modport sink   (input valid, min_ones_seg, min_tens_seg, hour_ones_seg, hour_tens_seg,
                  ring_blink, alarm_armed, alarm_lamp, output ready);
endinterface

@@ design/acde_step.sv @@
// Next-state and display logic for one command beat of the alarm clock.
// Purely combinational. Depends on acde_pkg.
module acde_step (
  input  acde_pkg::clk_state_t st,
  input  logic [1:0]           cmd,
  input  logic [3:0]           button_code,
  input  logic [2:0]           switch_bits,
  output acde_pkg::clk_state_t st_nxt,
  output acde_pkg::disp_t      disp,
  output logic                 emit
);
  import acde_pkg::*;

  function automatic logic [5:0] min_add(input logic [5:0] m, input logic [5:0] s);
    logic [6:0] v;
    v = {1'b0, m} + {1'b0, s};
    if (v >= {1'b0, MIN_WRAP}) begin
      v = v - {1'b0, MIN_WRAP};
    end
    return v[5:0];
  endfunction

  function automatic logic [5:0] min_sub(input logic [5:0] m, input logic [5:0] s);
    logic [5:0] v;
    if (m >= s) begin
      v = m - s;
    end else begin
      v = m + MIN_WRAP - s;
    end
    return v;
  endfunction

  function automatic logic [4:0] hour_add(input logic [4:0] h, input logic [5:0] s);
    logic [5:0] sum;
    logic [2:0] t;
    logic [3:0] o;
    logic [5:0] v;
    sum = {1'b0, h} + s;
    t   = tens_of(sum);
    o   = ones_of(sum);
    if (t == 3'd3) begin
      t = 3'd0;
    end
    v = 6'(t) * 6'd10 + {2'b00, o};
    if (v >= {1'b0, HOUR_WRAP}) begin
      v = v - {1'b0, HOUR_WRAP};
    end
    return v[4:0];
  endfunction

  logic [5:0] step;
  logic       on_min;
  logic [5:0] h6;
  logic [3:0] h_ones;
  logic [5:0] show_m;
  logic [4:0] show_h;
  logic       blank;
  logic       editing;
  logic [5:0] sec1;
  logic [5:0] min1;
  logic [4:0] hour1;
  logic       ring1;

  assign step    = st.digit_sel[0] ? 6'd10 : 6'd1;
  assign on_min  = !st.digit_sel[1];
  assign h6      = {1'b0, st.hour};
  assign h_ones  = ones_of(h6);
  assign editing = st.edit_time || st.edit_alarm;
  assign blank   = editing && !st.blink;
  assign show_m  = (!st.edit_time && st.edit_alarm) ? st.alarm_min  : st.min;
  assign show_h  = (!st.edit_time && st.edit_alarm) ? st.alarm_hour : st.hour;

  always_comb begin
    if (blank) begin
      disp.min_ones_seg  = SEG_BLANK;
      disp.min_tens_seg  = SEG_BLANK;
      disp.hour_ones_seg = SEG_BLANK;
      disp.hour_tens_seg = SEG_BLANK;
    end else begin
      disp.min_ones_seg  = seg_of(ones_of(show_m));
      disp.min_tens_seg  = seg_of({1'b0, tens_of(show_m)});
      disp.hour_ones_seg = seg_of(ones_of({1'b0, show_h}));
      disp.hour_tens_seg = seg_of({1'b0, tens_of({1'b0, show_h})});
    end
    disp.ring_blink  = st.blink && st.ringing;
    disp.alarm_armed = st.arm_on;
    disp.alarm_lamp  = st.lamp;
  end

  // clock advance by one second
  always_comb begin
    sec1  = st.sec + 6'd1;
    min1  = st.min;
    hour1 = st.hour;
    if (sec1 >= MIN_WRAP) begin
      sec1 = 6'd0;
      min1 = st.min + 6'd1;
    end
    if (min1 == MIN_WRAP) begin
      min1  = 6'd0;
      hour1 = st.hour + 5'd1;
    end
    if (hour1 >= HOUR_WRAP) begin
      hour1 = hour1 - HOUR_WRAP;
    end
    ring1 = st.ringing || (sec1 == RING_SEC && min1 == st.alarm_min &&
                           hour1 == st.alarm_hour && st.arm_on);
  end

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    case (cmd)
      CMD_TICK: begin
        emit = 1'b1;
        if (!editing) begin
          st_nxt.sec     = sec1;
          st_nxt.min     = min1;
          st_nxt.hour    = hour1;
          st_nxt.ringing = ring1;
          if (ring1) begin
            st_nxt.lamp  = st.blink ? LAMP_PH1 : LAMP_PH0;
            st_nxt.blink = !st.blink;
          end
        end else begin
          st_nxt.blink = !st.blink;
        end
      end
      CMD_BUTTON: begin
        case (button_code)
          BTN_ADD: begin
            if (st.edit_time) begin
              if (on_min) begin
                st_nxt.min = min_add(st.min, step);
              end else if (h6 + step >= {1'b0, HOUR_WRAP} && st.digit_sel == 2'd3) begin
                st_nxt.hour = {1'b0, h_ones};
              end else begin
                st_nxt.hour = hour_add(st.hour, step);
              end
            end else begin
              if (on_min) begin
                st_nxt.alarm_min = min_add(st.alarm_min, step);
              end else begin
                st_nxt.alarm_hour = hour_add(st.alarm_hour, step);
              end
            end
          end
          BTN_SUB: begin
            if (st.edit_time) begin
              if (on_min) begin
                st_nxt.min = min_sub(st.min, step);
              end else if (h6 < step) begin
                if (st.digit_sel == 2'd3) begin
                  st_nxt.hour = (h_ones <= 4'd3) ? 5'd20 + {1'b0, h_ones}
                                                 : 5'd10 + {1'b0, h_ones};
                end else begin
                  st_nxt.hour = HOUR_WRAP - 5'd1;
                end
              end else begin
                st_nxt.hour = 5'(h6 - step);
              end
            end else begin
              if (on_min) begin
                st_nxt.alarm_min = min_sub(st.alarm_min, step);
              end else if ({1'b0, st.alarm_hour} >= step) begin
                st_nxt.alarm_hour = 5'({1'b0, st.alarm_hour} - step);
              end else begin
                st_nxt.alarm_hour = 5'({1'b0, st.alarm_hour} + {1'b0, HOUR_WRAP} - step);
              end
            end
          end
          BTN_NEXT: begin
            st_nxt.digit_sel = st.digit_sel + 2'd1;
          end
          BTN_OFF: begin
            st_nxt.ringing = 1'b0;
            st_nxt.lamp    = LAMP_IDLE;
          end
          default: begin
          end
        endcase
      end
      CMD_SWITCH: begin
        st_nxt.digit_sel  = 2'd0;
        st_nxt.edit_time  = switch_bits[SW_EDIT_TIME];
        st_nxt.edit_alarm = switch_bits[SW_EDIT_ALARM];
        st_nxt.arm_on     = switch_bits[SW_ARM_ON];
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/alarm_clock_with_digit_edit_unit.sv @@
// Top level of the alarm clock with digit edit: input register, state and
// display register around acde_step. Depends on acde_pkg, acde_if, acde_step.
//
//   channel  dir  fields                                          beat
//   in_bus   in   cmd, button_code, switch_bits                   one command
//   out_bus  out  four segment codes, ring_blink, armed, lamp     one tick display
//
// One beat a cycle while out_bus is not stalled; the path from input to display is
// the input register, then the state update and display register in one pass.
// Button and switch beats update state and give no display beat.
// rst_n is synchronous: state returns to 23:59:55, alarm 17:00, no mode.
// A stalled out_bus holds the display; in_bus stalls once both registers are full.
module alarm_clock_with_digit_edit_unit (
  input logic        clk,
  input logic        rst_n,
  acde_in_if.sink    in_bus,
  acde_out_if.source out_bus
);
  import acde_pkg::*;

  clk_state_t st_r;
  clk_state_t st_nxt;
  disp_t      disp;
  disp_t      disp_r;
  logic       emit;
  logic       in_v_r;
  logic       out_v_r;
  logic [1:0] cmd_r;
  logic [3:0] code_r;
  logic [2:0] sw_r;
  logic       adv;

  assign adv          = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || adv;

  acde_step u_step (
    .st          (st_r),
    .cmd         (cmd_r),
    .button_code (code_r),
    .switch_bits (sw_r),
    .st_nxt      (st_nxt),
    .disp        (disp),
    .emit        (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= ST_RESET;
    end else begin
      if (in_bus.ready) begin
        in_v_r <= in_bus.valid;
      end
      if (adv) begin
        st_r    <= st_nxt;
        out_v_r <= emit;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      cmd_r  <= in_bus.cmd;
      code_r <= in_bus.button_code;
      sw_r   <= in_bus.switch_bits;
    end
    if (adv && emit) begin
      disp_r <= disp;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.min_ones_seg  = disp_r.min_ones_seg;
  assign out_bus.min_tens_seg  = disp_r.min_tens_seg;
  assign out_bus.hour_ones_seg = disp_r.hour_ones_seg;
  assign out_bus.hour_tens_seg = disp_r.hour_tens_seg;
  assign out_bus.ring_blink    = disp_r.ring_blink;
  assign out_bus.alarm_armed   = disp_r.alarm_armed;
  assign out_bus.alarm_lamp    = disp_r.alarm_lamp;

  a_tick_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cmd_r == CMD_TICK) |=> out_v_r)
    else $error("tick beat gave no display beat");

  a_quiet_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cmd_r != CMD_TICK) |=> !out_v_r)
    else $error("button or switch beat gave a display beat");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.sec < MIN_WRAP && st_r.min < MIN_WRAP && st_r.hour < HOUR_WRAP &&
     st_r.alarm_min < MIN_WRAP && st_r.alarm_hour < HOUR_WRAP))
    else $error("time or alarm out of range");

  a_alarm_off: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cmd_r == CMD_BUTTON && code_r == BTN_OFF) |=>
      (!st_r.ringing && st_r.lamp == LAMP_IDLE))
    else $error("alarm off did not silence");

endmodule
